[rtl/core/bhq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min-heap queue package
// Codes and control types shared by the queue top level and its cells.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_EMPTY      = 2'd2;

  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/bhq_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command channel
// Carries one insert or remove item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bhq_cmd_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

[rtl/core/bhq_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Carries one result item per command with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bhq_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] removed_value;
  logic signed [31:0] smallest;
  logic        [5:0]  count;
  logic        [1:0]  status;

  modport source (output valid, output removed_value, output smallest,
                  output count, output status, input ready);
  modport sink   (input valid, input removed_value, input smallest,
                  input count, input status, output ready);
endinterface
`default_nettype wire

[rtl/core/bhq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry of the sorted row and trades entries with its neighbors.
// ----------------------------------------------------------------------------
module bhq_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                            clk,
  input  bhq_pkg::cell_ctrl_t            ctrl,
  input  wire                            occupied,
  input  wire signed [VALUE_WIDTH-1:0]   ins_value,
  input  wire signed [VALUE_WIDTH-1:0]   left_value,
  input  wire                            left_keep,
  input  wire signed [VALUE_WIDTH-1:0]   right_value,
  output logic signed [VALUE_WIDTH-1:0]  value,
  output logic                           keep
);

  logic signed [VALUE_WIDTH-1:0] value_next;

  assign keep = occupied && (value <= ins_value);

  always_comb begin
    value_next = value;
    if (ctrl.do_insert) begin
      if (!keep) begin
        value_next = left_keep ? ins_value : left_value;
      end
    end else if (ctrl.do_remove) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

[rtl/core/binary_min_heap_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min priority queue
// Keeps the entries in a row of cells sorted from smallest to largest, so the
// first cell always holds the root of the queue.
// The result item is valid in the cycle after its command is accepted.
// One item per cycle unless results back up; every cell updates in parallel.
// Reset clears the entry count and the result valid flag; entries need no
// clearing, since only occupied cells are ever reported.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire       clk,
  input  wire       rst,
  bhq_cmd_if.sink   cmd,
  bhq_res_if.source res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic                          res_valid;
  logic signed [31:0]            removed;
  logic [1:0]                    status;
  logic                          accept;
  logic                          full;
  logic                          empty;
  bhq_pkg::cell_ctrl_t           ctrl;
  logic signed [VALUE_WIDTH-1:0] ins_value;
  logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic                          cell_keep  [CAPACITY];

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign ins_value = VALUE_WIDTH'(cmd.value);

  always_comb begin
    ctrl.do_insert = accept && (cmd.kind == bhq_pkg::KIND_INSERT) && !full;
    ctrl.do_remove = accept && (cmd.kind == bhq_pkg::KIND_REMOVE) && !empty;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                          occupied;
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_keep;
    logic signed [VALUE_WIDTH-1:0] right_value;

    assign occupied = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_value = ins_value;
      assign left_keep  = 1'b1;
    end else begin : g_inner
      assign left_value = cell_value[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    bhq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .ins_value  (ins_value),
      .left_value (left_value),
      .left_keep  (left_keep),
      .right_value(right_value),
      .value      (cell_value[i]),
      .keep       (cell_keep[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed <= ctrl.do_remove ? 32'(cell_value[0]) : 32'sd0;
      if (cmd.kind == bhq_pkg::KIND_INSERT) begin
        status <= full ? bhq_pkg::STATUS_FULL : bhq_pkg::STATUS_OK;
      end else begin
        status <= empty ? bhq_pkg::STATUS_EMPTY : bhq_pkg::STATUS_OK;
      end
    end
  end

  assign res.valid         = res_valid;
  assign res.removed_value = removed;
  assign res.smallest      = empty ? 32'sd0 : 32'(cell_value[0]);
  assign res.count         = 6'(count);
  assign res.status        = status;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("Accepted item produced no result.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("Entry count above capacity.");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == bhq_pkg::STATUS_FULL) |-> full)
    else $error("Insert rejected while space remained.");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == bhq_pkg::STATUS_EMPTY) |-> empty)
    else $error("Remove rejected while entries remained.");

  a_root_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
    else $error("Root is not the smallest entry.");

endmodule
`default_nettype wire
